// File: design/serial_frame_encoder_assert.svh
// assertion macros for the serial frame encoder
`ifndef SERIAL_FRAME_ENCODER_ASSERT_SVH
`define SERIAL_FRAME_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
`define SFE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("serial frame encoder check failed");
`define SFE_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("serial frame encoder forbidden condition");
`else
`define SFE_ASSERT(lbl, clk, rst_n, prop)
`define SFE_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// File: design/sfe_pkg.sv
// types and constants shared by the serial frame encoder modules
package sfe_pkg;

    localparam logic [7:0] CH_START  = 8'h23;
    localparam logic [7:0] CH_OFFSET = 8'h3d;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] ADDR_RESET = 8'h62;

    localparam int MaxVals = 4;

    typedef logic [5:0] t_sextet;

    typedef struct packed {
        logic                      hdr;
        logic [7:0]                cmd;
        logic [7:0]                addr;
        logic [2:0]                count;
        t_sextet [MaxVals-1:0]     vals;
        logic                      last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: design/sfe_if.sv
// channel interfaces of the serial frame encoder
interface sfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] command_char;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       first_of_frame;
    logic       last_of_frame;

    modport source (output valid, command_char, payload_byte, byte_valid,
                    first_of_frame, last_of_frame, input ready);
    modport sink (input valid, command_char, payload_byte, byte_valid,
                  first_of_frame, last_of_frame, output ready);
endinterface

interface sfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_end;
    logic       frame_end;

    modport source (output valid, out_char, run_end, frame_end, input ready);
    modport sink (input valid, out_char, run_end, frame_end, output ready);
endinterface

interface sfe_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] device_address;

    modport source (output valid, device_address, input ready);
    modport sink (input valid, device_address, output ready);
endinterface

// File: design/sfe_front.sv
// front end: accepts items, tracks the byte group and builds character jobs
module sfe_front import sfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfe_in_if.sink     i_in,
    input  logic [7:0] i_device_address,
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_job       o_job
);

    logic [1:0] r_phase;
    logic [3:0] r_carry;
    logic [1:0] n_phase;
    logic [3:0] n_carry;
    logic       w_accept;
    t_job       w_job;

    always_comb begin
        t_sextet [MaxVals-1:0] vals;
        logic [2:0]            cnt;
        logic [7:0]            b;
        b       = i_in.payload_byte;
        vals    = '0;
        cnt     = 3'd0;
        n_phase = (i_in.first_of_frame || r_phase == 2'd3) ? 2'd0 : r_phase;
        n_carry = i_in.first_of_frame ? 4'd0 : r_carry;
        if (i_in.byte_valid) begin
            case (n_phase)
                2'd1: begin
                    vals[0] = {n_carry[1:0], b[7:4]};
                    n_carry = b[3:0];
                    n_phase = 2'd2;
                    cnt     = 3'd1;
                end
                2'd2: begin
                    vals[0] = {n_carry, b[7:6]};
                    vals[1] = b[5:0];
                    n_carry = 4'd0;
                    n_phase = 2'd0;
                    cnt     = 3'd2;
                end
                default: begin
                    vals[0] = b[7:2];
                    n_carry = {2'b00, b[1:0]};
                    n_phase = 2'd1;
                    cnt     = 3'd1;
                end
            endcase
        end
        if (i_in.last_of_frame) begin
            if (n_phase == 2'd1) begin
                if (cnt == 3'd0) begin
                    vals[0] = {n_carry[1:0], 4'b0000};
                end else begin
                    vals[1] = {n_carry[1:0], 4'b0000};
                end
                cnt = cnt + 3'd3;
            end else if (n_phase == 2'd2) begin
                if (cnt == 3'd0) begin
                    vals[0] = {n_carry, 2'b00};
                end else begin
                    vals[1] = {n_carry, 2'b00};
                end
                cnt = cnt + 3'd2;
            end
            n_phase = 2'd0;
            n_carry = 4'd0;
        end
        w_job.hdr   = i_in.first_of_frame;
        w_job.cmd   = i_in.command_char;
        w_job.addr  = i_device_address;
        w_job.count = cnt;
        w_job.vals  = vals;
        w_job.last  = i_in.last_of_frame;
    end

    assign i_in.ready = !i_q_status.full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign o_push     = w_accept && (w_job.hdr || w_job.last || w_job.count != 3'd0);
    assign o_job      = w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_carry <= 4'd0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule

// File: design/sfe_queue.sv
// job queue between the front end and the character sequencer
module sfe_queue import sfe_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_job,
    output t_q_status o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_job  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// File: design/sfe_back.sv
// back end: walks each job and sends its characters with the running checksum
module sfe_back import sfe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  t_q_status i_q_status,
    output logic      o_pop,
    sfe_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_START,
        S_HDR0,
        S_HDR1,
        S_HDR2,
        S_DATA,
        S_CKHI,
        S_CKLO,
        S_CR
    } t_step;

    t_step       r_step;
    logic [1:0]  r_idx;
    logic [11:0] r_sum;
    logic        r_valid;
    logic [7:0]  r_char;
    logic        r_run_end;
    logic        r_frame_end;

    t_step       w_cur;
    t_step       n_step;
    logic [1:0]  n_idx;
    logic [11:0] n_sum;
    logic [7:0]  w_char;
    logic        w_done;
    logic        w_cr;
    logic        w_fire;

    always_comb begin
        t_step after_data;
        after_data = i_job.last ? S_CKHI : S_START;
        if (r_step == S_START) begin
            w_cur = i_job.hdr ? S_HDR0 : ((i_job.count != 3'd0) ? S_DATA : S_CKHI);
        end else begin
            w_cur = r_step;
        end
        w_char = 8'd0;
        w_done = 1'b0;
        w_cr   = 1'b0;
        n_step = S_START;
        n_idx  = 2'd0;
        n_sum  = r_sum;
        case (w_cur)
            S_HDR0: begin
                w_char = CH_START;
                n_sum  = {4'd0, CH_START};
                n_step = S_HDR1;
            end
            S_HDR1: begin
                w_char = i_job.addr;
                n_sum  = r_sum + {4'd0, w_char};
                n_step = S_HDR2;
            end
            S_HDR2: begin
                w_char = i_job.cmd;
                n_sum  = r_sum + {4'd0, w_char};
                n_step = (i_job.count != 3'd0) ? S_DATA : after_data;
                w_done = (i_job.count == 3'd0) && !i_job.last;
            end
            S_DATA: begin
                w_char = CH_OFFSET + {2'b00, i_job.vals[r_idx]};
                n_sum  = r_sum + {4'd0, w_char};
                if ({1'b0, r_idx} + 3'd1 == i_job.count) begin
                    n_step = after_data;
                    w_done = !i_job.last;
                end else begin
                    n_step = S_DATA;
                    n_idx  = r_idx + 2'd1;
                end
            end
            S_CKHI: begin
                w_char = CH_OFFSET + {2'b00, r_sum[11:6]};
                n_step = S_CKLO;
            end
            S_CKLO: begin
                w_char = CH_OFFSET + {2'b00, r_sum[5:0]};
                n_step = S_CR;
            end
            S_CR: begin
                w_char = CH_CR;
                w_cr   = 1'b1;
                w_done = 1'b1;
                n_sum  = 12'd0;
            end
            default: begin
                w_done = 1'b1;
            end
        endcase
        if (w_done) begin
            n_step = S_START;
            n_idx  = 2'd0;
        end
    end

    assign w_fire = !i_q_status.empty && (!r_valid || o_out.ready);
    assign o_pop  = w_fire && w_done;

    assign o_out.valid     = r_valid;
    assign o_out.out_char  = r_char;
    assign o_out.run_end   = r_run_end;
    assign o_out.frame_end = r_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= S_START;
            r_idx   <= 2'd0;
            r_sum   <= 12'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_step  <= n_step;
                r_idx   <= n_idx;
                r_sum   <= n_sum;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_char      <= w_char;
            r_run_end   <= w_done;
            r_frame_end <= w_cr;
        end
    end

endmodule

// File: design/serial_frame_encoder.sv
// top level of the serial frame encoder
// The front end takes one input transaction per cycle whenever the job queue
// (QUEUE_DEPTH jobs) has room, and turns it into a job of 1 to 10 characters
// (header, packed 6-bit data characters, padding, checksum and carriage return).
// The back end sends one character per cycle through a registered output while
// the sink is ready, and finishes each job before it takes the next; a payload byte
// in mid-frame causes about 1.33 characters. Items that cause no character are
// absorbed by the front end and queue no job. The device address register resets
// to 'b' and is written through the configuration channel, which is always ready.
`include "serial_frame_encoder_assert.svh"

module serial_frame_encoder import sfe_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfe_in_if.sink    i_in,
    sfe_cfg_if.sink   i_cfg,
    sfe_out_if.source o_out
);

    logic [7:0] r_device_address;
    logic       w_push;
    logic       w_pop;
    t_job       w_front_job;
    t_job       w_back_job;
    t_q_status  w_q_status;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= ADDR_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_device_address <= i_cfg.device_address;
        end
    end

    sfe_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in             (i_in),
        .i_device_address (r_device_address),
        .i_q_status       (w_q_status),
        .o_push           (w_push),
        .o_job            (w_front_job)
    );

    sfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_front_job),
        .i_pop    (w_pop),
        .o_job    (w_back_job),
        .o_status (w_q_status)
    );

    sfe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_back_job),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

    `SFE_ASSERT(a_cr_closes_run, i_clk, i_rst_n, (o_out.valid && o_out.frame_end) |-> (o_out.out_char == CH_CR && o_out.run_end))
    `SFE_NEVER(a_queue_full_empty, i_clk, i_rst_n, w_q_status.full && w_q_status.empty)
    `SFE_ASSERT(a_pop_marks_run_end, i_clk, i_rst_n, w_pop |=> (o_out.valid && o_out.run_end))

endmodule

// File: sim/tb_serial_frame_encoder.sv
// self-checking testbench for the serial frame encoder with a built-in frame predictor
`timescale 1ns / 100ps

module tb_serial_frame_encoder;
    import sfe_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       frame_end;
    } t_frame_char;

    logic clk;
    logic rst_n;

    sfe_in_if  in_ch();
    sfe_cfg_if cfg_ch();
    sfe_out_if out_ch();

    serial_frame_encoder i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    t_frame_char expected_chars[$];
    logic [7:0]  addr_char = ADDR_RESET;
    logic [11:0] chk_sum   = '0;
    logic [1:0]  byte_slot = '0;
    logic [3:0]  held_bits = '0;

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int src_idle_pct   = 32;
    int snk_idle_pct   = 45;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic push_char(input logic [7:0] ch, input bit summed, input bit is_cr);
        t_frame_char c;
        c.ch        = ch;
        c.run_end   = 1'b0;
        c.frame_end = is_cr;
        expected_chars.push_back(c);
        if (summed) chk_sum = chk_sum + 12'(ch);
    endtask

    task automatic encode_item(input logic [7:0] cmd, input logic [7:0] data,
                               input logic bv, input logic first, input logic last);
        int n0;
        n0 = expected_chars.size();
        if (byte_slot == 2'd3) byte_slot = 2'd0;
        if (first) begin
            chk_sum   = '0;
            byte_slot = '0;
            held_bits = '0;
            push_char(CH_START, 1, 0);
            push_char(addr_char, 1, 0);
            push_char(cmd, 1, 0);
        end
        if (bv) begin
            case (byte_slot)
                2'd0: begin
                    push_char(CH_OFFSET + {2'b00, data[7:2]}, 1, 0);
                    held_bits = {2'b00, data[1:0]};
                    byte_slot = 2'd1;
                end
                2'd1: begin
                    push_char(CH_OFFSET + {2'b00, held_bits[1:0], data[7:4]}, 1, 0);
                    held_bits = data[3:0];
                    byte_slot = 2'd2;
                end
                default: begin
                    push_char(CH_OFFSET + {2'b00, held_bits, data[7:6]}, 1, 0);
                    push_char(CH_OFFSET + {2'b00, data[5:0]}, 1, 0);
                    held_bits = '0;
                    byte_slot = 2'd0;
                end
            endcase
        end
        if (last) begin
            // pad a short group with zero bytes
            if (byte_slot == 2'd1) begin
                push_char(CH_OFFSET + {2'b00, held_bits[1:0], 4'b0000}, 1, 0);
                push_char(CH_OFFSET, 1, 0);
                push_char(CH_OFFSET, 1, 0);
            end else if (byte_slot == 2'd2) begin
                push_char(CH_OFFSET + {2'b00, held_bits, 2'b00}, 1, 0);
                push_char(CH_OFFSET, 1, 0);
            end
            push_char(CH_OFFSET + {2'b00, chk_sum[11:6]}, 0, 0);
            push_char(CH_OFFSET + {2'b00, chk_sum[5:0]}, 0, 0);
            push_char(CH_CR, 0, 1);
            chk_sum   = '0;
            byte_slot = '0;
            held_bits = '0;
        end
        if (expected_chars.size() > n0)
            expected_chars[expected_chars.size() - 1].run_end = 1'b1;
    endtask

    always @(posedge clk) begin : check_outputs
        t_frame_char want;
        bit          moved;
        if (rst_n) begin
            moved = 1'b0;
            if (cfg_ch.valid && cfg_ch.ready) begin
                addr_char = cfg_ch.device_address;
                moved = 1'b1;
            end
            if (in_ch.valid && in_ch.ready) begin
                encode_item(in_ch.command_char, in_ch.payload_byte, in_ch.byte_valid,
                            in_ch.first_of_frame, in_ch.last_of_frame);
                moved = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                moved = 1'b1;
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected out_char expected none got %h",
                             $time, out_ch.out_char);
                    mismatch_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (want.ch !== out_ch.out_char) begin
                        $display("%0t: out_char expected %h got %h",
                                 $time, want.ch, out_ch.out_char);
                        mismatch_count++;
                    end
                    if (want.run_end !== out_ch.run_end) begin
                        $display("%0t: run_end expected %b got %b",
                                 $time, want.run_end, out_ch.run_end);
                        mismatch_count++;
                    end
                    if (want.frame_end !== out_ch.frame_end) begin
                        $display("%0t: frame_end expected %b got %b",
                                 $time, want.frame_end, out_ch.frame_end);
                        mismatch_count++;
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("tb_serial_frame_encoder failed");
        $finish;
    end

    task automatic send_item(input logic [7:0] cmd, input logic [7:0] data,
                             input logic bv, input logic first, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.command_char   <= cmd;
        in_ch.payload_byte   <= data;
        in_ch.byte_valid     <= bv;
        in_ch.first_of_frame <= first;
        in_ch.last_of_frame  <= last;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_address(input logic [7:0] addr);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.device_address <= addr;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_frame_layout();
        // empty frame, then one, two and three payload bytes
        send_item(8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
        send_item(8'hff, 8'hff, 1'b1, 1'b1, 1'b1);
        send_item(8'h41, 8'h00, 1'b1, 1'b1, 1'b0);
        send_item(8'h00, 8'hff, 1'b1, 1'b0, 1'b1);
        send_item(8'h7e, 8'ha5, 1'b1, 1'b1, 1'b0);
        send_item(8'h00, 8'h5a, 1'b1, 1'b0, 1'b0);
        send_item(8'h00, 8'hff, 1'b1, 1'b0, 1'b1);
        // idle transaction
        send_item(8'hff, 8'hff, 1'b0, 1'b0, 1'b0);
        // header while a frame is open
        send_item(8'h12, 8'h12, 1'b1, 1'b1, 1'b0);
        send_item(8'h00, 8'h34, 1'b1, 1'b0, 1'b0);
        send_item(8'h80, 8'h56, 1'b1, 1'b1, 1'b0);
        send_item(8'h00, 8'h78, 1'b1, 1'b0, 1'b1);
        // a byte with no header, flushed by a bare last
        send_item(8'h00, 8'h9c, 1'b1, 1'b0, 1'b0);
        send_item(8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
        // bare last after two bytes
        send_item(8'h55, 8'h01, 1'b1, 1'b1, 1'b0);
        send_item(8'h00, 8'h02, 1'b1, 1'b0, 1'b0);
        send_item(8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
        // bare last with no frame open
        send_item(8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
        wait_drain();
    endtask

    task automatic test_address_register();
        write_address(8'h00);
        send_item(8'h3c, 8'hc3, 1'b1, 1'b1, 1'b0);
        send_item(8'h00, 8'h0f, 1'b1, 1'b0, 1'b1);
        wait_drain();
        write_address(8'hff);
        send_item(8'haa, 8'h00, 1'b0, 1'b1, 1'b1);
        send_item(8'h01, 8'hf0, 1'b1, 1'b1, 1'b1);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int n_items, input int src_pct,
                                       input int snk_pct);
        int sent;
        int r;
        int len;
        bit trailing;
        bit paused;
        logic [4:0] flags;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        wait_drain();
        write_address(8'($urandom_range(255)));
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            if (!paused && sent >= n_items / 2) begin
                wait_drain();
                paused = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 70) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(24, 13) : $urandom_range(7, 0);
                trailing = ($urandom_range(3) == 0);
                if (len == 0) begin
                    send_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                              1'b0, 1'b1, 1'b1);
                    sent++;
                end else begin
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(9) == 0)
                            send_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                                      1'b0, 1'b0, 1'b0);
                        send_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                                  1'b1, i == 0, (i == len - 1) && !trailing);
                        sent++;
                    end
                    if (trailing) begin
                        send_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                                  1'b0, 1'b0, 1'b1);
                        sent++;
                    end
                end
            end else if (r < 82) begin
                send_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                          1'b0, 1'b0, 1'b0);
            end else if (r < 94) begin
                flags = 5'($urandom_range(31));
                send_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                          flags[0], flags[1], flags[2]);
                if (flags[2:0] != 3'b000) sent++;
            end else begin
                // frame abandoned before its last byte
                len = $urandom_range(4, 1);
                for (int i = 0; i < len; i++) begin
                    send_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                              1'b1, i == 0, 1'b0);
                    sent++;
                end
            end
        end
        wait_drain();
    endtask

    initial begin
        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.command_char   = '0;
        in_ch.payload_byte   = '0;
        in_ch.byte_valid     = 1'b0;
        in_ch.first_of_frame = 1'b0;
        in_ch.last_of_frame  = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.device_address = '0;
        out_ch.ready          = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_frame_layout();
        test_address_register();
        test_random_traffic(160, 32, 45);
        test_random_traffic(160, 45, 32);
        test_random_traffic(160, 0, 0);

        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("tb_serial_frame_encoder passed");
        end else begin
            $display("tb_serial_frame_encoder failed");
        end
        $finish;
    end

endmodule
